/* sv/hvd_pkg.sv */
// Package for the hydraulic valve drive: field widths, valve type codes and duty constants.
`default_nettype none

package hvd_pkg;

	localparam int unsigned CmdW   = 11;
	localparam int unsigned DutyW  = 11;
	localparam int unsigned TypeW  = 3;
	localparam int unsigned AmpW   = 7;
	localparam int unsigned DirW   = 2;
	localparam int unsigned InW    = 16;
	localparam int unsigned OutW   = 16;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgW   = 7;

	// Valve type codes
	localparam logic [TypeW-1:0] VT_NONE     = 3'd0;
	localparam logic [TypeW-1:0] VT_TWO_COIL = 3'd1;
	localparam logic [TypeW-1:0] VT_DITHERED = 3'd2;
	localparam logic [TypeW-1:0] VT_COARSE   = 3'd3;
	localparam logic [TypeW-1:0] VT_DISK     = 3'd4;
	localparam logic [TypeW-1:0] VT_RAW      = 3'd5;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_VALVE_TYPE = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_DITHER_AMP = 1'd1;

	// Item kinds on the input tuser
	localparam logic ACT_SET  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// Direction codes
	localparam logic [DirW-1:0] DIR_NONE = 2'd0;
	localparam logic [DirW-1:0] DIR_A    = 2'd1;
	localparam logic [DirW-1:0] DIR_B    = 2'd2;

	localparam logic [AmpW-1:0] AMP_RESET = 7'd10;

	// Reciprocals for division by 5, 10 and 125 of magnitudes up to 1024.
	localparam logic [11:0] RECIP5   = 12'd3277;   // shift 14
	localparam logic [12:0] RECIP10  = 13'd6554;   // shift 16
	localparam logic [13:0] RECIP125 = 14'd8389;   // shift 20

	// Dithered type: duty = floor(v * 26 / 25) - 40, with v = 450/550 +- c/5.
	localparam logic signed [11:0] FINE_POS_BASE = 12'sd532;
	localparam logic signed [11:0] FINE_NEG_BASE = 12'sd428;
	localparam logic signed [11:0] FINE_ZERO     = 12'sd480;
	// Coarse type: 440/550 +- c/10, centre 480.
	localparam logic signed [11:0] COARSE_POS_BASE = 12'sd550;
	localparam logic signed [11:0] COARSE_NEG_BASE = 12'sd440;
	localparam logic signed [11:0] COARSE_ZERO     = 12'sd480;

	// Direction thresholds of the dithered type
	localparam logic signed [DutyW-1:0] DIR_LOW_LIM  = 11'sd430;
	localparam logic signed [DutyW-1:0] DIR_HIGH_LIM = 11'sd530;

	localparam logic signed [11:0] DUTY_MAX = 12'sd1000;

	typedef struct packed {
		logic [DirW-1:0]         direction;
		logic                    coil_b;
		logic                    coil_a;
		logic                    pwm_used;
		logic signed [DutyW-1:0] pwm_duty;
	} result_t;

endpackage

`default_nettype wire

/* sv/hydraulic_valve_drive.sv */
// Hydraulic valve drive: turns set and dither tick items into coil levels and a PWM duty.
//
// Input channel s_*: one item per handshake. s_tuser is the item kind (set or
// 100 ms dither tick); s_tdata carries the command and the mode flags.
// Output channel m_*: zero or one result item per input item, with duty,
// coil levels and the direction the valve had before the item.
// Configuration: cfg_we/cfg_index/cfg_data write valve type (index 0) and
// dither amplitude (index 1); the user must write them only while the block is
// idle, which the block itself does not enforce. An accepted item is held in
// the input register; its result is loaded into the output register when that
// register is empty or being read, and m_tvalid then rises if there is a result.
// Throughput: one item per cycle; the input register drains into the output
// register whenever that register is empty or being read.
// When the receiver stalls, the result holds in the output register, the
// next item waits in the input register, and s_tready drops until m_tready.
// Reset clears both valid flags, the valve type (none), the stored duty, the
// coil levels and the dither phase; the dither amplitude resets to 10.
`default_nettype none

module hydraulic_valve_drive (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// [10:0] command, [11] manual_mode, [12] oil_present, [13] emergency, [15:14] zero
	input  wire  [hvd_pkg::InW-1:0]      s_tdata,
	// [0] action
	input  wire                          s_tuser,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// [10:0] pwm_duty, [11] pwm_used, [12] coil_a, [13] coil_b, [15:14] direction
	output logic [hvd_pkg::OutW-1:0]     m_tdata,
	input  wire                          cfg_we,
	input  wire  [hvd_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire  [hvd_pkg::CfgW-1:0]     cfg_data
);
	import hvd_pkg::*;

	// Configuration registers
	logic [TypeW-1:0] valve_type_q;
	logic [AmpW-1:0]  dither_amp_q;

	// Valve state
	logic signed [DutyW-1:0] stored_duty_q;
	logic                    coil_a_q;
	logic                    coil_b_q;
	logic [1:0]              phase_q;

	// Input register
	logic                    valid_s1;
	logic                    action_s1;
	logic signed [CmdW-1:0]  command_s1;
	logic                    manual_s1;
	logic                    enabled_s1;

	// Output register
	logic    out_valid_q;
	result_t out_q;

	logic advance;

	// Next state and result
	logic signed [DutyW-1:0] duty_d;
	logic                    coil_a_d;
	logic                    coil_b_d;
	logic [1:0]              phase_d;
	logic                    emit;
	result_t                 res;
	logic [DirW-1:0]         dir;

	// Arithmetic
	logic [CmdW-1:0]         mag;
	logic [22:0]             prod5;
	logic [23:0]             prod10;
	logic [24:0]             prod125;
	logic [7:0]              q5;
	logic [6:0]              q10;
	logic [3:0]              k125;
	logic [7:0]              k125_x25;
	logic                    rem25;
	logic signed [11:0]      fine_duty;
	logic signed [11:0]      coarse_duty;
	logic [1:0]              phase_inc;
	logic signed [11:0]      dither_term;
	logic signed [11:0]      dither_sum;
	logic signed [DutyW-1:0] dither_duty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valve_type_q <= VT_NONE;
			dither_amp_q <= AMP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VALVE_TYPE: valve_type_q <= cfg_data[TypeW-1:0];
				REG_DITHER_AMP: dither_amp_q <= cfg_data[AmpW-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1  <= s_tuser;
			command_s1 <= $signed(s_tdata[CmdW-1:0]);
			manual_s1  <= s_tdata[11];
			enabled_s1 <= s_tdata[12] && !s_tdata[13];
		end
	end

	// Magnitude of the command and its quotients by reciprocal multiplication.
	always_comb begin
		mag      = command_s1[CmdW-1] ? CmdW'(-command_s1) : CmdW'(command_s1);
		prod5    = 23'(mag) * 23'(RECIP5);
		prod10   = 24'(mag) * 24'(RECIP10);
		prod125  = 25'(mag) * 25'(RECIP125);
		q5       = prod5[21:14];
		q10      = prod10[22:16];
		k125     = prod125[23:20];
		// floor(q5/25) equals floor(mag/125); a remainder means the ceiling is one higher.
		k125_x25 = 8'(k125) * 8'd25;
		rem25    = (q5 != k125_x25);
	end

	always_comb begin
		if (command_s1 > 0) begin
			fine_duty   = FINE_POS_BASE + $signed({4'b0, q5}) + $signed({8'b0, k125});
			coarse_duty = COARSE_POS_BASE + $signed({5'b0, q10});
		end else if (command_s1 < 0) begin
			fine_duty   = FINE_NEG_BASE - $signed({4'b0, q5}) - $signed({8'b0, k125})
				- $signed({11'b0, rem25});
			coarse_duty = COARSE_NEG_BASE - $signed({5'b0, q10});
		end else begin
			fine_duty   = FINE_ZERO;
			coarse_duty = COARSE_ZERO;
		end
	end

	// Dither: counter 0, 1, 2, -1 times the amplitude, added to the stored duty.
	always_comb begin
		phase_inc = phase_q + 2'd1;
		unique case (phase_inc)
			2'd0: dither_term = 12'sd0;
			2'd1: dither_term = $signed({5'b0, dither_amp_q});
			2'd2: dither_term = $signed({4'b0, dither_amp_q, 1'b0});
			2'd3: dither_term = -$signed({5'b0, dither_amp_q});
			default: dither_term = 12'sd0;
		endcase
		dither_sum = 12'(stored_duty_q) + dither_term;
		if (dither_sum < 0) begin
			dither_duty = '0;
		end else if (dither_sum > DUTY_MAX) begin
			dither_duty = DutyW'(DUTY_MAX);
		end else begin
			dither_duty = DutyW'(dither_sum);
		end
	end

	always_comb begin
		if (valve_type_q == VT_TWO_COIL || valve_type_q == VT_DISK) begin
			dir = coil_a_q ? DIR_A : (coil_b_q ? DIR_B : DIR_NONE);
		end else if (valve_type_q == VT_DITHERED && stored_duty_q < DIR_LOW_LIM) begin
			dir = DIR_A;
		end else if (valve_type_q == VT_DITHERED && stored_duty_q > DIR_HIGH_LIM) begin
			dir = DIR_B;
		end else begin
			dir = DIR_NONE;
		end
	end

	always_comb begin
		duty_d   = stored_duty_q;
		coil_a_d = coil_a_q;
		coil_b_d = coil_b_q;
		phase_d  = phase_q;
		emit     = 1'b0;
		res      = '0;
		res.direction = dir;
		if (action_s1 == ACT_TICK) begin
			if (valve_type_q == VT_DITHERED) begin
				phase_d      = phase_inc;
				emit         = 1'b1;
				res.pwm_used = 1'b1;
				res.pwm_duty = enabled_s1 ? dither_duty : '0;
			end
		end else begin
			unique case (valve_type_q)
				VT_TWO_COIL: begin
					coil_a_d   = command_s1 < 0;
					coil_b_d   = command_s1 > 0;
					emit       = 1'b1;
					res.coil_a = enabled_s1 && coil_a_d;
					res.coil_b = enabled_s1 && coil_b_d;
				end
				VT_DISK: begin
					coil_a_d   = command_s1 != 0;
					emit       = 1'b1;
					res.coil_a = enabled_s1 && coil_a_d;
				end
				VT_DITHERED: begin
					duty_d       = DutyW'(fine_duty);
					emit         = 1'b1;
					res.pwm_used = 1'b1;
					res.pwm_duty = enabled_s1 ? duty_d : '0;
				end
				VT_COARSE: begin
					duty_d       = DutyW'(coarse_duty);
					emit         = 1'b1;
					res.pwm_used = 1'b1;
					res.pwm_duty = enabled_s1 ? duty_d : '0;
				end
				VT_RAW: begin
					duty_d       = command_s1;
					emit         = 1'b1;
					res.pwm_used = 1'b1;
					res.pwm_duty = enabled_s1 ? command_s1 : '0;
					res.coil_a   = enabled_s1 && (command_s1 == 11'sd1);
				end
				default: ;
			endcase
		end
		// Manual mode keeps the state update but drops the result.
		if (manual_s1) begin
			emit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_duty_q <= '0;
			coil_a_q      <= 1'b0;
			coil_b_q      <= 1'b0;
			phase_q       <= 2'd0;
		end else if (advance) begin
			stored_duty_q <= duty_d;
			coil_a_q      <= coil_a_d;
			coil_b_q      <= coil_b_d;
			phase_q       <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// A result that drives the PWM output never drives coil B.
	a_pwm_no_coil_b: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.pwm_used |-> !out_q.coil_b)
		else $error("coil B driven together with PWM");

	// Coil-only results carry zero duty.
	a_coil_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !out_q.pwm_used |-> out_q.pwm_duty == '0)
		else $error("duty nonzero on coil-only result");

	// A waiting result holds its data until it is taken.
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A dither tick result stays within the duty range.
	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && action_s1 == ACT_TICK |=>
		out_q.pwm_duty >= 0 && out_q.pwm_duty <= 11'sd1000)
		else $error("dithered duty out of range");

	// The dither phase only moves on an accepted tick.
	a_phase_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && action_s1 == ACT_TICK) |=> $stable(phase_q))
		else $error("dither phase moved without a tick");

endmodule

`default_nettype wire
